FILE: sv/bfp_pkg.sv
// Package for the two-probe Bloom filter: op codes, hash constant, sizing limits.
// No dependencies; imported by bfp_probe and bloom_filter_two_probe_top.
package bfp_pkg;

  // Command codes carried on op_i
  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  // Golden-ratio multiplier for the second probe
  localparam logic [63:0] ProbeMult = 64'h9e37_79b9_7f4a_7c15;

  // Smallest filter: 2^12 bits, i.e. 64 words
  localparam int unsigned MinLog2 = 12;

  // Default word depth of the filter memory
  localparam int unsigned DefMaxWords = 256;

  // Reset value of the size register
  localparam logic [3:0] SizeLog2Reset = 4'd12;

endpackage

FILE: sv/bfp_probe.sv
// Probe unit: derives the two bit positions from a 64-bit key hash.
// Depends on bfp_pkg (ProbeMult). Results are registered on load_i.
module bfp_probe
  import bfp_pkg::*;
#(
  parameter int unsigned PW = 14
) (
  input  logic          clk_i,
  input  logic          load_i,
  input  logic [63:0]   hash_i,
  input  logic [PW-1:0] mask_i,
  output logic [PW-1:0] b1_o,
  output logic [PW-1:0] b2_o
);

  // Only the low PW bits of the product survive the mask, so a PW x PW multiply does
  localparam logic [PW-1:0] MultLo = ProbeMult[PW-1:0];

  logic [2*PW-1:0] prod_full;
  logic [PW-1:0]   b1_d, b2_d;
  logic [PW-1:0]   b1_q, b2_q;

  assign prod_full = (2*PW)'(hash_i[PW-1:0]) * (2*PW)'(MultLo);

  // Probe one: hash masked; probe two: high half xor product, masked
  assign b1_d = hash_i[PW-1:0] & mask_i;
  assign b2_d = (hash_i[PW+31:32] ^ prod_full[PW-1:0]) & mask_i;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
    end
  end

  assign b1_o = b1_q;
  assign b2_o = b2_q;

endmodule

FILE: sv/bfp_ram.sv
// Single-port synchronous RAM holding the filter words, with a registered read port.
// No dependencies. A read in the cycle of a write to the same word returns old data.
module bfp_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  input  logic          we_i,
  input  logic [63:0]   wdata_i,
  output logic [63:0]   rdata_o
);

  logic [63:0] mem [DEPTH];
  logic [63:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/bloom_filter_two_probe_top.sv
// Top level of the two-probe Bloom filter: command sequencer around the word RAM.
// Depends on bfp_pkg, bfp_probe and bfp_ram.
//
//  channel   | signals                               | handshake
//  ----------+---------------------------------------+------------------------------
//  command   | op_i, hash_value_i                    | start && !busy
//  result    | may_contain_o                         | valid_o, one cycle, no stall
//  config    | cfg_wdata_i (size_bits_log2)          | cfg_we_i
//
// Insert and query pass from the accepted beat to the result strobe through the
// probe register, read word one, modify word one, read and modify word two, all
// through the single RAM port. A clear zeroes 2^(size_log2-6) words, one word per
// cycle; op 3 answers without a RAM access. After reset all MAX_WORDS words are
// swept to zero, busy high. A new beat may be accepted in the cycle of the strobe.
module bloom_filter_two_probe_top
  import bfp_pkg::*;
#(
  parameter int unsigned MAX_WORDS = DefMaxWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op_i,
  input  logic [63:0] hash_value_i,
  output logic        valid_o,
  output logic        may_contain_o,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i
);

  localparam int unsigned AW      = $clog2(MAX_WORDS);
  localparam int unsigned FitLog2 = 6 + $clog2(MAX_WORDS + 1) - 1;
  localparam int unsigned LgMax   = (FitLog2 > MinLog2) ? FitLog2 : MinLog2;
  localparam int unsigned PW      = LgMax;
  localparam logic [4:0]  LgMin5  = 5'(MinLog2);
  localparam logic [4:0]  LgMax5  = 5'(LgMax);
  localparam logic [AW-1:0] LastInit = AW'(MAX_WORDS - 1);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_RD1,
    S_MOD1,
    S_RD2,
    S_MOD2,
    S_CLR
  } state_e;

  state_e      state_q;
  logic [3:0]  size_q;
  logic [1:0]  op_q;
  logic [AW-1:0] cnt_q;
  logic        hit1_q;
  logic        valid_q;
  logic        may_q;

  logic [4:0]    lg_eff;
  logic [AW:0]   words;
  logic [AW-1:0] last_word;
  logic [PW:0]   mask_wide;
  logic [PW-1:0] mask;
  logic          accept;
  logic [PW-1:0] b1, b2;
  logic [AW-1:0] w1, w2;
  logic [5:0]    pos1, pos2;
  logic [AW-1:0] ram_addr;
  logic          ram_we;
  logic [63:0]   ram_wdata;
  logic [63:0]   ram_rdata;

  // Size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeLog2Reset;
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // Effective size: clamp to the supported range
  always_comb begin
    lg_eff = {1'b0, size_q};
    if (lg_eff < LgMin5) begin
      lg_eff = LgMin5;
    end else if (lg_eff > LgMax5) begin
      lg_eff = LgMax5;
    end
  end

  assign words     = (AW + 1)'(1) << (lg_eff - 5'd6);
  assign last_word = AW'(words - (AW + 1)'(1));
  assign mask_wide = ((PW + 1)'(1) << lg_eff) - (PW + 1)'(1);
  assign mask      = mask_wide[PW-1:0];

  assign accept = start && !busy;

  bfp_probe #(
    .PW (PW)
  ) u_probe (
    .clk_i  (clk_i),
    .load_i (accept),
    .hash_i (hash_value_i),
    .mask_i (mask),
    .b1_o   (b1),
    .b2_o   (b2)
  );

  // Word index and bit position of each probe
  assign w1   = AW'(b1[PW-1:6]);
  assign w2   = AW'(b2[PW-1:6]);
  assign pos1 = b1[5:0];
  assign pos2 = b2[5:0];

  // RAM port steering
  always_comb begin
    ram_addr  = w1;
    ram_we    = 1'b0;
    ram_wdata = ram_rdata | (64'd1 << pos1);
    case (state_q)
      S_INIT, S_CLR: begin
        ram_addr  = cnt_q;
        ram_we    = 1'b1;
        ram_wdata = '0;
      end
      S_MOD1: begin
        ram_addr = w1;
        ram_we   = (op_q == OP_INSERT);
      end
      S_RD2: begin
        ram_addr = w2;
      end
      S_MOD2: begin
        ram_addr  = w2;
        ram_we    = (op_q == OP_INSERT);
        ram_wdata = ram_rdata | (64'd1 << pos2);
      end
      default: begin
        ram_addr = w1;
      end
    endcase
  end

  bfp_ram #(
    .DEPTH (MAX_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .addr_i  (ram_addr),
    .we_i    (ram_we),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      op_q    <= OP_CLEAR;
      cnt_q   <= '0;
      hit1_q  <= 1'b0;
      valid_q <= 1'b0;
      may_q   <= 1'b0;
    end else begin
      valid_q <= 1'b0;
      case (state_q)
        S_INIT: begin
          if (cnt_q == LastInit) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        S_IDLE: begin
          if (start) begin
            op_q <= op_i;
            case (op_i)
              OP_CLEAR: begin
                cnt_q   <= '0;
                state_q <= S_CLR;
              end
              OP_INSERT, OP_QUERY: begin
                state_q <= S_RD1;
              end
              default: begin
                valid_q <= 1'b1;
                may_q   <= 1'b0;
              end
            endcase
          end
        end
        S_RD1: begin
          state_q <= S_MOD1;
        end
        S_MOD1: begin
          hit1_q  <= ram_rdata[pos1];
          state_q <= S_RD2;
        end
        S_RD2: begin
          state_q <= S_MOD2;
        end
        S_MOD2: begin
          valid_q <= 1'b1;
          may_q   <= (op_q == OP_QUERY) && hit1_q && ram_rdata[pos2];
          state_q <= S_IDLE;
        end
        S_CLR: begin
          if (cnt_q == last_word) begin
            cnt_q   <= '0;
            valid_q <= 1'b1;
            may_q   <= 1'b0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + AW'(1);
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy          = (state_q != S_IDLE);
  assign valid_o       = valid_q;
  assign may_contain_o = may_q;

  // An accepted beat either starts work or answers at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || valid_o))
    else $error("accepted beat neither started nor answered");

  // The result strobe always lands with the sequencer back at rest
  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> !busy)
    else $error("result strobe while sequencer busy");

  // Only inserts and sweeps write the RAM
  a_write_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != S_CLR && state_q != S_INIT) |-> (op_q == OP_INSERT))
    else $error("RAM written outside insert or sweep");

  // A clear never walks past the words in use
  a_clear_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLR) |-> (cnt_q <= last_word))
    else $error("clear walk beyond filter size");

endmodule

FILE: verif/bfp_filter_checker.sv
`timescale 1ns / 100ps
// Checker for the two-probe Bloom filter: mirrors the filter word array and size register,
// predicts may_contain per command beat and compares it with each result strobe.
// Depends on bfp_pkg.
module bfp_filter_checker
  import bfp_pkg::*;
#(
  parameter int unsigned MAX_WORDS = DefMaxWords
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  op_i,
  input  logic [63:0] hash_value_i,
  input  logic        valid_i,
  input  logic        may_contain_i,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_wdata_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);

  // One outstanding answer, kept with its command for the mismatch report
  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] hash;
    logic        may_contain;
  } answer_t;

  logic [63:0] filter_mem [MAX_WORDS];
  logic [3:0]  size_log2;
  answer_t     answer_q [$];

  // Size actually in use: raised to the minimum, lowered until it fits the RAM
  function automatic int unsigned used_log2(logic [3:0] req);
    int unsigned lg;
    lg = req;
    if (lg < MinLog2) lg = MinLog2;
    while (lg > MinLog2 && (64'd1 << (lg - 6)) > MAX_WORDS) lg--;
    return lg;
  endfunction

  // Applies one command to the mirrored filter and returns its may_contain answer
  function automatic logic apply_command(logic [1:0] op, logic [63:0] h);
    int unsigned lg;
    logic [63:0] mask;
    logic [63:0] prod;
    logic [63:0] b1;
    logic [63:0] b2;
    logic        hit;
    lg   = used_log2(size_log2);
    mask = (64'd1 << lg) - 64'd1;
    prod = h * ProbeMult;
    b1   = h & mask;
    b2   = ((h >> 32) ^ prod) & mask;
    hit  = 1'b0;
    case (op)
      OP_CLEAR: begin
        for (int unsigned w = 0; w < (1 << (lg - 6)); w++) filter_mem[w] = '0;
      end
      OP_INSERT: begin
        filter_mem[b1 >> 6][b1[5:0]] = 1'b1;
        filter_mem[b2 >> 6][b2[5:0]] = 1'b1;
      end
      OP_QUERY: begin
        hit = filter_mem[b1 >> 6][b1[5:0]] && filter_mem[b2 >> 6][b2[5:0]];
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  // Result beat is checked before the command beat of the same edge: it is always older
  always @(posedge clk_i or negedge rst_ni) begin
    answer_t exp_ans;
    if (!rst_ni) begin
      for (int unsigned w = 0; w < MAX_WORDS; w++) filter_mem[w] = '0;
      size_log2 = SizeLog2Reset;
      answer_q.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (valid_i) begin
        if (answer_q.size() == 0) begin
          $display("%0t: unexpected result beat, may_contain=%0b", $realtime, may_contain_i);
          fail_count_o++;
        end else begin
          exp_ans = answer_q.pop_front();
          if (may_contain_i !== exp_ans.may_contain) begin
            $display("%0t: may_contain mismatch (op %0d hash %h): expected %0b, actual %0b",
                     $realtime, exp_ans.op, exp_ans.hash, exp_ans.may_contain, may_contain_i);
            fail_count_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        exp_ans.op          = op_i;
        exp_ans.hash        = hash_value_i;
        exp_ans.may_contain = apply_command(op_i, hash_value_i);
        answer_q.push_back(exp_ans);
      end
      if (cfg_we_i) size_log2 = cfg_wdata_i;
      pending_o = answer_q.size();
    end
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// Testbench top for the two-probe Bloom filter: clock, reset, command and size stimulus,
// verdict. Depends on bfp_pkg, bloom_filter_two_probe_top and bfp_filter_checker.
module tb
  import bfp_pkg::*;
();

  localparam logic [1:0] OpUnused   = 2'd3;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned PhaseBeats = 150;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  op_i;
  logic [63:0] hash_value_i;
  logic        valid_o;
  logic        may_contain_o;
  logic        cfg_we_i;
  logic [3:0]  cfg_wdata_i;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned burst_left;
  logic [63:0] key_pool [$];
  logic [63:0] stale_keys [4];

  bloom_filter_two_probe_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .hash_value_i  (hash_value_i),
    .valid_o       (valid_o),
    .may_contain_o (may_contain_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  bfp_filter_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .op_i          (op_i),
    .hash_value_i  (hash_value_i),
    .valid_i       (valid_o),
    .may_contain_i (may_contain_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Idle cycles after a beat: mostly none or short, a few long, with gap-free bursts
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) burst_left = $urandom_range(40, 10);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic [63:0] rand_hash();
    return {$urandom, $urandom};
  endfunction

  // Drive one beat from a falling edge, hold it until accepted, then idle for any picked gap
  task automatic send_beat(input logic [1:0] op, input logic [63:0] h);
    int unsigned gap;
    start        <= 1'b1;
    op_i         <= op;
    hash_value_i <= h;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    if (op == OP_INSERT) begin
      key_pool.push_back(h);
      if (key_pool.size() > 200) void'(key_pool.pop_front());
    end
    gap = pick_gap();
    if (gap != 0) begin
      start        <= 1'b0;
      op_i         <= 2'($urandom);
      hash_value_i <= rand_hash();
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // Size write with the block idle: all answers in, command line low
  task automatic write_size(input logic [3:0] lg);
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0 || busy);
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= lg;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 4'($urandom);
    @(negedge clk_i);
  endtask

  // Random beats: new-key inserts and mostly known-key queries dominate, clears are rare
  task automatic run_random(input int unsigned n);
    int unsigned r;
    logic [63:0] h;
    for (int unsigned i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (key_pool.size() != 0 && $urandom_range(99) < 60)
        h = key_pool[$urandom_range(key_pool.size() - 1)];
      else
        h = rand_hash();
      if (r < 40)      send_beat(OP_INSERT, rand_hash());
      else if (r < 88) send_beat(OP_QUERY, h);
      else if (r < 92) send_beat(OP_CLEAR, rand_hash());
      else if (r < 96) send_beat(OpUnused, h);
      else             send_beat(OP_INSERT, h);
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    op_i         = OP_CLEAR;
    hash_value_i = '0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = '0;
    burst_left   = 0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty filter, extreme hashes, unused op, clear
    write_size(4'd12);
    send_beat(OP_QUERY, 64'h0);
    send_beat(OP_INSERT, 64'h0);
    send_beat(OP_QUERY, 64'h0);
    send_beat(OP_INSERT, '1);
    send_beat(OP_QUERY, '1);
    send_beat(OP_QUERY, 64'hFFFF_FFFF_0000_0000);
    send_beat(OP_INSERT, 64'h0000_0000_FFFF_FFFF);
    send_beat(OP_QUERY, 64'h0000_0000_FFFF_FFFF);
    send_beat(OpUnused, '1);
    send_beat(OP_CLEAR, '1);
    send_beat(OP_QUERY, '1);
    send_beat(OP_QUERY, 64'h0);

    // A clear at a smaller size leaves old bits in the upper words for a later larger size
    write_size(4'd14);
    for (int i = 0; i < 4; i++) begin
      stale_keys[i] = rand_hash();
      send_beat(OP_INSERT, stale_keys[i]);
    end
    write_size(4'd12);
    send_beat(OP_CLEAR, 64'h0);
    write_size(4'd14);
    for (int i = 0; i < 4; i++) send_beat(OP_QUERY, stale_keys[i]);

    // Random phases over several sizes, out-of-range values included
    run_random(PhaseBeats);
    write_size(4'd13);
    run_random(PhaseBeats);
    write_size(4'd0);
    run_random(PhaseBeats);
    write_size(4'd15);
    run_random(PhaseBeats);
    write_size(4'd11);
    run_random(PhaseBeats);
    write_size(4'd12);
    run_random(PhaseBeats);

    // Drain
    start <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (16) @(negedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
